>>> hdl/vrf_pkg.sv
// ----------------------------------------------------------------------------
// vrf_pkg
// Shared types and constants of the 2-D vector rotate/flip block.
// ----------------------------------------------------------------------------
`default_nettype none

package vrf_pkg;

  // coefficient format: signed Q2.16
  localparam int COEF_W  = 18;
  localparam int Q_FRAC  = 16;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int ANGLE_REG_W = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FLIP_X = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_FLIP_Y = CFG_INDEX_W'(2);

  // series evaluation in Q62
  localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q16_ROUND    = 64'h0000_2000_0000_0000;
  localparam int          SERIES_TERMS = 24;
  localparam int          TERM_CNT_W   = 5;
  localparam int          DIVISOR_W    = 12;
  localparam logic [16:0] Q16_ONE      = 17'd65536;

  typedef enum logic [3:0] {
    T_IDLE,
    T_XM_GO,
    T_XM_WAIT,
    T_SQ_GO,
    T_SQ_WAIT,
    T_TM_GO,
    T_TM_WAIT,
    T_DV_WAIT,
    T_ROUND
  } trig_state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cosine;
    logic signed [COEF_W-1:0] sine;
  } trig_t;

  typedef struct packed {
    logic flip_x;
    logic flip_y;
  } flip_t;

endpackage

`default_nettype wire

>>> hdl/vrf_mul64.sv
// ----------------------------------------------------------------------------
// vrf_mul64
// Unsigned 64x64 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_mul64 (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      prod
);

  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [127:0] acc;
  logic [1:0]   step;
  logic         run;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] pp_shifted;

  always_comb begin
    a_part     = step[1] ? a_q[63:32] : a_q[31:0];
    b_part     = step[0] ? b_q[63:32] : b_q[31:0];
    pp         = {32'b0, a_part} * {32'b0, b_part};
    pos        = {1'b0, step[1]} + {1'b0, step[0]};
    pp_shifted = {64'b0, pp} << {pos, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      acc <= '0;
    end else if (run) begin
      acc <= acc + pp_shifted;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

>>> hdl/vrf_div.sv
// ----------------------------------------------------------------------------
// vrf_div
// Restoring divider, 64-bit dividend by a small divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [63:0]                    dividend,
  input  wire logic [vrf_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                done,
  output logic [63:0]                         quotient
);

  localparam int DW = vrf_pkg::DIVISOR_W;

  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [63:0]   quo;
  logic [5:0]    cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem, quo[63]};
    ge    = trial >= {1'b0, dv};
    diff  = trial - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (run) begin
      // remainder stays below the divisor, so the low bits hold it
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> hdl/vrf_trig.sv
// ----------------------------------------------------------------------------
// vrf_trig
// Cosine/sine sequencer: evaluates Taylor series in Q62 on an angle write and
// holds the Q2.16 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_trig #(
  parameter int ANGLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic                       busy,
  output vrf_pkg::trig_t             trig
);

  localparam int SH = ANGLE_BITS - 2;
  localparam logic [63:0]   HP_HI = vrf_pkg::HALF_PI_Q62 >> SH;
  localparam logic [SH-1:0] HP_LO = vrf_pkg::HALF_PI_Q62[SH-1:0];
  localparam int TW = vrf_pkg::TERM_CNT_W;
  localparam int CW = vrf_pkg::COEF_W;

  vrf_pkg::trig_state_t state;
  vrf_pkg::trig_state_t state_next;

  logic [1:0]    quad;
  logic [SH-1:0] k;
  logic [63:0]   xr;
  logic [63:0]   x2;
  logic [63:0]   term;
  logic [63:0]   sum;
  logic [TW-1:0] n;
  logic          is_sin;
  logic [16:0]   sin_r;

  logic          mul_start;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic          mul_done;
  logic [127:0]  mul_prod;
  logic          div_start;
  logic          div_done;
  logic [63:0]   div_quo;

  logic [2*SH-1:0]               lo_prod;
  logic [5:0]                    n2;
  logic [5:0]                    fac;
  logic [vrf_pkg::DIVISOR_W-1:0] divisor;
  logic [63:0]                   rsum;
  logic [17:0]                   rq;
  logic [16:0]                   r17;
  logic                          last_term;

  vrf_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  vrf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[125:62]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    lo_prod   = {{SH{1'b0}}, HP_LO} * {{SH{1'b0}}, k};
    n2        = {n, 1'b0};
    fac       = is_sin ? n2 + 6'd1 : n2 - 6'd1;
    divisor   = {6'b0, n2} * {6'b0, fac};
    rsum      = sum + vrf_pkg::Q16_ROUND;
    rq        = rsum[63:46];
    // negative sum (series undershoot) reads as zero, clamp at one
    if (sum[63])
      r17 = '0;
    else if (rq > {1'b0, vrf_pkg::Q16_ONE})
      r17 = vrf_pkg::Q16_ONE;
    else
      r17 = rq[16:0];
    last_term = (n == TW'(vrf_pkg::SERIES_TERMS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrf_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = term;
    mul_b      = x2;
    case (state)
      vrf_pkg::T_IDLE: begin
        if (load) state_next = vrf_pkg::T_XM_GO;
      end
      vrf_pkg::T_XM_GO: begin
        mul_start  = 1'b1;
        mul_a      = HP_HI;
        mul_b      = 64'(k);
        state_next = vrf_pkg::T_XM_WAIT;
      end
      vrf_pkg::T_XM_WAIT: begin
        if (mul_done) state_next = vrf_pkg::T_SQ_GO;
      end
      vrf_pkg::T_SQ_GO: begin
        mul_start  = 1'b1;
        mul_a      = xr;
        mul_b      = xr;
        state_next = vrf_pkg::T_SQ_WAIT;
      end
      vrf_pkg::T_SQ_WAIT: begin
        if (mul_done) state_next = vrf_pkg::T_TM_GO;
      end
      vrf_pkg::T_TM_GO: begin
        mul_start  = 1'b1;
        state_next = vrf_pkg::T_TM_WAIT;
      end
      vrf_pkg::T_TM_WAIT: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = vrf_pkg::T_DV_WAIT;
        end
      end
      vrf_pkg::T_DV_WAIT: begin
        if (div_done) state_next = last_term ? vrf_pkg::T_ROUND : vrf_pkg::T_TM_GO;
      end
      vrf_pkg::T_ROUND: begin
        state_next = is_sin ? vrf_pkg::T_TM_GO : vrf_pkg::T_IDLE;
      end
      default: begin
        state_next = vrf_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      vrf_pkg::T_IDLE: begin
        if (load) begin
          quad <= angle[ANGLE_BITS-1:SH];
          k    <= angle[SH-1:0];
        end
      end
      vrf_pkg::T_XM_WAIT: begin
        if (mul_done) xr <= mul_prod[63:0] + 64'(lo_prod >> SH);
      end
      vrf_pkg::T_SQ_WAIT: begin
        if (mul_done) begin
          x2     <= mul_prod[125:62];
          term   <= xr;
          sum    <= xr;
          n      <= TW'(1);
          is_sin <= 1'b1;
        end
      end
      vrf_pkg::T_DV_WAIT: begin
        if (div_done) begin
          term <= div_quo;
          sum  <= n[0] ? sum - div_quo : sum + div_quo;
          if (!last_term) n <= n + TW'(1);
        end
      end
      vrf_pkg::T_ROUND: begin
        if (is_sin) begin
          sin_r  <= r17;
          is_sin <= 1'b0;
          term   <= vrf_pkg::ONE_Q62;
          sum    <= vrf_pkg::ONE_Q62;
          n      <= TW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // coefficient registers, updated once both series are done
  always_ff @(posedge clk) begin
    if (rst) begin
      trig.cosine <= CW'(65536);
      trig.sine   <= '0;
    end else if (state == vrf_pkg::T_ROUND && !is_sin) begin
      case (quad)
        2'd0: begin
          trig.sine   <= $signed({1'b0, sin_r});
          trig.cosine <= $signed({1'b0, r17});
        end
        2'd1: begin
          trig.sine   <= $signed({1'b0, r17});
          trig.cosine <= -$signed({1'b0, sin_r});
        end
        2'd2: begin
          trig.sine   <= -$signed({1'b0, sin_r});
          trig.cosine <= -$signed({1'b0, r17});
        end
        default: begin
          trig.sine   <= -$signed({1'b0, r17});
          trig.cosine <= $signed({1'b0, sin_r});
        end
      endcase
    end
  end

  assign busy = (state != vrf_pkg::T_IDLE);

endmodule

`default_nettype wire

>>> hdl/vrf_rotate.sv
// ----------------------------------------------------------------------------
// vrf_rotate
// Pipelined rotation datapath: coefficient select, split multiplies,
// product sums, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_rotate #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y,
  input  wire logic                          command,
  input  wire vrf_pkg::trig_t                trig,
  input  wire vrf_pkg::flip_t                flips,
  output logic                               done,
  output logic signed [COORD_WIDTH-1:0]      rotated_x,
  output logic signed [COORD_WIDTH-1:0]      rotated_y,
  output logic                               saturated
);

  localparam int W  = COORD_WIDTH;
  localparam int LO = W / 2;
  localparam int HI = W - LO;
  localparam int KW = vrf_pkg::COEF_W;
  localparam int SW = W + KW + 1;
  localparam int LPW = LO + 1 + KW;
  localparam int HPW = HI + KW;

  // stage 0: input register and coefficient select
  logic                 v0;
  logic signed [W-1:0]  x0, y0;
  logic signed [KW-1:0] kxx, kxy, kyx, kyy;

  // stage 1: partial products
  logic                  v1;
  logic signed [LPW-1:0] lxx, lxy, lyx, lyy;
  logic signed [HPW-1:0] hxx, hxy, hyx, hyy;

  // stage 2: full products
  logic                 v2;
  logic signed [SW-1:0] fxx, fxy, fyx, fyy;

  // stage 3: sums
  logic                 v3;
  logic signed [SW-1:0] sx, sy;

  logic [W:0] res_x, res_y;

  function automatic logic [W:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] q;
    logic [W:0]           o;
    r = v + (SW'(1) <<< (vrf_pkg::Q_FRAC - 1));
    q = r >>> vrf_pkg::Q_FRAC;
    if (q[SW-1:W-1] == '0 || q[SW-1:W-1] == '1)
      o = {1'b0, q[W-1:0]};
    else if (q[SW-1])
      o = {1'b1, 1'b1, {(W-1){1'b0}}};
    else
      o = {1'b1, 1'b0, {(W-1){1'b1}}};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // flips fold into the coefficient signs
    if (in_valid) begin
      x0  <= coord_x;
      y0  <= coord_y;
      kxx <= flips.flip_x ? -trig.cosine : trig.cosine;
      kyy <= flips.flip_y ? -trig.cosine : trig.cosine;
      kxy <= (flips.flip_y ^ command) ? -trig.sine : trig.sine;
      kyx <= (flips.flip_x ^ ~command) ? -trig.sine : trig.sine;
    end
    if (v0) begin
      lxx <= $signed({1'b0, x0[LO-1:0]}) * kxx;
      lxy <= $signed({1'b0, y0[LO-1:0]}) * kxy;
      lyx <= $signed({1'b0, x0[LO-1:0]}) * kyx;
      lyy <= $signed({1'b0, y0[LO-1:0]}) * kyy;
      hxx <= $signed(x0[W-1:LO]) * kxx;
      hxy <= $signed(y0[W-1:LO]) * kxy;
      hyx <= $signed(x0[W-1:LO]) * kyx;
      hyy <= $signed(y0[W-1:LO]) * kyy;
    end
    if (v1) begin
      fxx <= (SW'(hxx) <<< LO) + SW'(lxx);
      fxy <= (SW'(hxy) <<< LO) + SW'(lxy);
      fyx <= (SW'(hyx) <<< LO) + SW'(lyx);
      fyy <= (SW'(hyy) <<< LO) + SW'(lyy);
    end
    if (v2) begin
      sx <= fxx + fxy;
      sy <= fyx + fyy;
    end
    if (v3) begin
      rotated_x <= res_x[W-1:0];
      rotated_y <= res_y[W-1:0];
      saturated <= res_x[W] | res_y[W];
    end
  end

  always_comb begin
    res_x = round_sat(sx);
    res_y = round_sat(sy);
  end

endmodule

`default_nettype wire

>>> hdl/vector_rotate_flip_2d_top.sv
// ----------------------------------------------------------------------------
// vector_rotate_flip_2d_top
// Rotates a signed Q16.16 vector by a programmed binary angle, with optional
// negation of x and y before the rotation.
// ----------------------------------------------------------------------------
// result path: an accepted start passes the input, partial-product, full-product,
//   sum and output registers to done; one request per cycle while busy is low, and the result strobe cannot be stalled
// an angle write runs the cosine/sine sequencer: 48 series terms, each a
//   multiply followed by a divide, with busy high until it is done
// reset: cosine = 1.0, sine = 0, flips cleared; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module vector_rotate_flip_2d_top #(
  parameter int ANGLE_BITS  = 12,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [COORD_WIDTH-1:0]      coord_x,
  input  wire logic signed [COORD_WIDTH-1:0]      coord_y,
  input  wire logic                               command,
  output logic                                    done,
  output logic signed [COORD_WIDTH-1:0]           rotated_x,
  output logic signed [COORD_WIDTH-1:0]           rotated_y,
  output logic                                    saturated,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [vrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [vrf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  vrf_pkg::trig_t trig;
  vrf_pkg::flip_t flips;
  logic           trig_busy;
  logic           cfg_we;
  logic           angle_load;

  assign cfg_ready  = ~trig_busy;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign angle_load = cfg_we && (cfg_index == vrf_pkg::REG_ANGLE);
  assign busy       = trig_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      flips <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vrf_pkg::REG_FLIP_X: flips.flip_x <= cfg_data[0];
        vrf_pkg::REG_FLIP_Y: flips.flip_y <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  vrf_trig #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .load  (angle_load),
    .angle (ANGLE_BITS'(cfg_data[vrf_pkg::ANGLE_REG_W-1:0])),
    .busy  (trig_busy),
    .trig  (trig)
  );

  vrf_rotate #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~trig_busy),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .command   (command),
    .trig      (trig),
    .flips     (flips),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

>>> hdl/vrf_checker.sv
// ----------------------------------------------------------------------------
// vrf_checker
// Port-level checks of the rotate block: result timing, sequencer start and
// saturation values.
// ----------------------------------------------------------------------------
`default_nettype none

module vrf_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic signed [COORD_WIDTH-1:0]   rotated_x,
  input wire logic signed [COORD_WIDTH-1:0]   rotated_y,
  input wire logic                            saturated,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [vrf_pkg::CFG_INDEX_W-1:0] cfg_index
);

  localparam logic [COORD_WIDTH-1:0] MAX_V = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_V = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // every accepted request is followed by a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted request produced no result");

  // no result without a matching earlier request
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  // an angle write starts the coefficient sequencer
  a_angle_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == vrf_pkg::REG_ANGLE) |=> busy)
    else $error("angle write did not start coefficient update");

  // a clipped result shows a range limit
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (rotated_x == MAX_V || rotated_x == MIN_V ||
       rotated_y == MAX_V || rotated_y == MIN_V))
    else $error("saturation flag without a clipped component");

endmodule

bind vector_rotate_flip_2d_top vrf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_vrf_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .rotated_x (rotated_x),
  .rotated_y (rotated_y),
  .saturated (saturated),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

`default_nettype wire
